FILE: rtl/hash_map_triangular_probe_defines.svh
// Assertion macros shared by the hash map RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef HASH_MAP_TRIANGULAR_PROBE_DEFINES_SVH
`define HASH_MAP_TRIANGULAR_PROBE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define HMTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle implies a result in the next cycle.
`define HMTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HMTP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/hmtp_pkg.sv
// Package for the triangular-probe hash map: widths, codes and payload types.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package hmtp_pkg;

  localparam int unsigned MAX_SLOTS_LOG2 = 10;
  localparam int unsigned KEY_WIDTH      = 32;
  localparam int unsigned VALUE_WIDTH    = 32;
  localparam int unsigned HASH_WIDTH     = 32;

  // Table size register.
  localparam int unsigned CFG_WIDTH   = 4;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 4'd10;
  localparam int unsigned MIN_LOG2    = 1;

  // Load limit is (size * LOAD_NUM) >> LOAD_SHIFT.
  localparam int unsigned LOAD_NUM   = 100;
  localparam int unsigned LOAD_SHIFT = 7;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_TABLE_SIZE_LOG2 = 1'b0;

  typedef enum logic {
    KIND_FIND = 1'b0,
    KIND_SET  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [KEY_WIDTH-1:0]   key_id;
    logic [HASH_WIDTH-1:0]  key_hash;
    logic [VALUE_WIDTH-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] value_out;
    logic                   refused;
  } rsp_t;

endpackage

FILE: rtl/hash_map_triangular_probe.sv
// Top level of the open-addressed hash map with triangular probing.
// Depends on hmtp_pkg, hmtp_ram and hash_map_triangular_probe_defines.svh.
`timescale 1ns / 1ps
`include "hash_map_triangular_probe_defines.svh"

// Usage
// The request channel (in_valid_i / in_ready_o / in_data_i) takes one find or
// set per transfer. The response channel (out_valid_o / out_ready_i /
// out_data_o) returns exactly one result per request, in request order.
// The table size register sits at byte address 0 of the APB-style port and
// should only be written while no request is outstanding.
// A request probes the slots of its triangular sequence one after another,
// k = 1 up to the table size, and its result goes into the output register
// once the last probe resolves; the block is back in idle as the result
// shows up, and it takes no new request while probing. The single read port
// of the slot RAM sets this pace: each probe is one registered read whose
// data is compared in the next cycle. After reset the block sweeps the slot
// RAM once to mark every slot empty; in_ready_o stays low during the sweep.
// Register writes are still taken during that sweep.
// If the receiver stalls, the finished result waits in the output register;
// the next request can still be accepted and probed, and it holds at its
// final probe until the output register frees up.
module hash_map_triangular_probe #(
  parameter int unsigned MAX_SLOTS_LOG2 = hmtp_pkg::MAX_SLOTS_LOG2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hmtp_pkg::req_t                  in_data_i,
  // Response channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hmtp_pkg::rsp_t                  out_data_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hmtp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hmtp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hmtp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned DEPTH  = 1 << MAX_SLOTS_LOG2;
  localparam int unsigned IDX_W  = MAX_SLOTS_LOG2;
  // Wide enough to hold the slot count itself.
  localparam int unsigned CNT_W  = MAX_SLOTS_LOG2 + 1;
  localparam int unsigned LOG_W  = $clog2(MAX_SLOTS_LOG2 + 1);
  localparam int unsigned PROD_W = CNT_W + hmtp_pkg::LOAD_SHIFT;
  localparam int unsigned KW     = hmtp_pkg::KEY_WIDTH;
  localparam int unsigned VW     = hmtp_pkg::VALUE_WIDTH;
  // RAM word: valid flag, key, value.
  localparam int unsigned RAM_W  = 1 + KW + VW;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROBE = 3'b100
  } state_e;

  state_e                           state_q, state_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [CNT_W-1:0]                 step_q, step_d;
  logic [CNT_W-1:0]                 used_q, used_d;
  logic [IDX_W-1:0]                 clr_q, clr_d;
  logic [hmtp_pkg::CFG_WIDTH-1:0]   cfg_q;
  hmtp_pkg::req_t                   req_q, req_d;
  logic                             out_valid_q, out_valid_d;
  hmtp_pkg::rsp_t                   out_q, out_d;

  // Slot RAM ports.
  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [RAM_W-1:0]                 ram_wdata;
  logic [IDX_W-1:0]                 ram_raddr;
  logic [RAM_W-1:0]                 ram_rdata;

  // Table geometry derived from the size register.
  logic [LOG_W-1:0]                 eff_log2;
  logic [CNT_W-1:0]                 size;
  logic [IDX_W-1:0]                 mask;
  logic [PROD_W-1:0]                load_prod;
  logic [CNT_W-1:0]                 cap;

  // Probe evaluation.
  logic                             slot_vld;
  logic [KW-1:0]                    slot_key;
  logic [VW-1:0]                    slot_val;
  logic                             hit;
  logic                             empty;
  logic                             last;
  logic                             resolve;
  logic                             can_finish;
  logic [IDX_W-1:0]                 next_idx;
  logic                             cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration register. Out-of-range values are clamped on use, not on
  // write, so a read returns the low CFG_WIDTH bits exactly as written.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == hmtp_pkg::REG_TABLE_SIZE_LOG2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= hmtp_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      cfg_q <= pwdata[hmtp_pkg::CFG_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hmtp_pkg::REG_TABLE_SIZE_LOG2) begin
      prdata[hmtp_pkg::CFG_WIDTH-1:0] = cfg_q;
    end
  end

  always_comb begin
    if (int'(cfg_q) < int'(hmtp_pkg::MIN_LOG2)) begin
      eff_log2 = LOG_W'(hmtp_pkg::MIN_LOG2);
    end else if (int'(cfg_q) > int'(MAX_SLOTS_LOG2)) begin
      eff_log2 = LOG_W'(MAX_SLOTS_LOG2);
    end else begin
      eff_log2 = LOG_W'(cfg_q);
    end
  end

  assign size      = CNT_W'(1) << eff_log2;
  assign mask      = IDX_W'(size - CNT_W'(1));
  // The load limit is a constant multiply of a narrow value.
  assign load_prod = PROD_W'(size) * PROD_W'(hmtp_pkg::LOAD_NUM);
  assign cap       = CNT_W'(load_prod >> hmtp_pkg::LOAD_SHIFT);

  // ---------------------------------------------------------------------------
  // Probe datapath. The RAM word read for idx_q is compared in this cycle;
  // the next triangular slot is idx + step, wrapped to the table size.
  // ---------------------------------------------------------------------------
  assign slot_vld   = ram_rdata[RAM_W-1];
  assign slot_key   = ram_rdata[KW+VW-1:VW];
  assign slot_val   = ram_rdata[VW-1:0];
  assign empty      = !slot_vld;
  assign hit        = slot_vld && (slot_key == req_q.key_id);
  assign last       = (step_q == size);
  assign resolve    = empty || hit || last;
  assign can_finish = !out_valid_q || out_ready_i;
  assign next_idx   = (idx_q + IDX_W'(step_q)) & mask;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    step_d      = step_q;
    used_d      = used_q;
    clr_d       = clr_q;
    req_d       = req_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_raddr   = idx_q;

    // A pending result leaves when the receiver takes it.
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ST_CLEAR: begin
        // One slot per cycle is marked empty.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // The first slot is read while the request is being offered, so its
        // data is ready in the first probe cycle.
        ram_raddr = in_data_i.key_hash[IDX_W-1:0] & mask;
        if (in_valid_i) begin
          req_d   = in_data_i;
          idx_d   = in_data_i.key_hash[IDX_W-1:0] & mask;
          step_d  = CNT_W'(1);
          state_d = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (!resolve) begin
          idx_d     = next_idx;
          step_d    = step_q + CNT_W'(1);
          ram_raddr = next_idx;
        end else if (can_finish) begin
          out_valid_d       = 1'b1;
          out_d.found       = hit;
          out_d.value_out   = '0;
          out_d.refused     = 1'b0;
          state_d           = ST_IDLE;
          if (req_q.kind == hmtp_pkg::KIND_FIND) begin
            if (hit) begin
              out_d.value_out = slot_val;
            end
          end else if (empty) begin
            if (used_q <= cap) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, req_q.key_id, req_q.value_in};
              used_d    = used_q + CNT_W'(1);
            end else begin
              out_d.refused = 1'b1;
            end
          end else if (hit) begin
            // Overwrite of a present key keeps the count unchanged.
            ram_we    = 1'b1;
            ram_wdata = {1'b1, slot_key, req_q.value_in};
          end else begin
            // Every slot was visited without a match or a free slot.
            out_d.refused = 1'b1;
          end
        end
        // Otherwise the result is held back: the read address stays on the
        // same slot so the compare data stays valid.
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    req_q <= req_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  hmtp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HMTP_ASSERT(a_used_bound, used_q <= CNT_W'(DEPTH), "slot count exceeds table depth")

  `HMTP_ASSERT(a_step_bound,
               (state_q != ST_PROBE) || ((step_q != '0) && (step_q <= size)),
               "probe step outside the table size")

  `HMTP_ASSERT_NEXT(a_accept_probe, in_valid_i && in_ready_o,
                    (state_q == ST_PROBE) && !in_ready_o,
                    "accepted request did not start probing")

  `HMTP_ASSERT_NEXT(a_count_only_on_insert, state_q != ST_PROBE,
                    used_q == $past(used_q),
                    "slot count changed outside a probe")

endmodule

FILE: rtl/hmtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hmtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/hmtp_checker.sv
// Checker for the triangular-probe hash map: tracks the size register, keeps its own
// copy of the slot table, predicts one reply per request and compares in order.
// Depends on hmtp_pkg for the payload types, widths and load-limit constants.
`timescale 1ns / 1ps

module hmtp_checker #(
  parameter logic [hmtp_pkg::APB_ADDR_W-1:0] SIZE_REG_ADDR = '0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  hmtp_pkg::req_t                  req_i,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  hmtp_pkg::rsp_t                  rsp_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [hmtp_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [hmtp_pkg::APB_DATA_W-1:0] pwdata_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     results_o,
  output int unsigned                     hits_o,
  output int unsigned                     refusals_o
);

  import hmtp_pkg::*;

  localparam int unsigned SLOTS = 1 << MAX_SLOTS_LOG2;

  logic                   slot_full [SLOTS];
  logic [KEY_WIDTH-1:0]   slot_key  [SLOTS];
  logic [VALUE_WIDTH-1:0] slot_val  [SLOTS];
  int unsigned            fill_count;
  logic [CFG_WIDTH-1:0]   size_log2;

  rsp_t replies_due [$];
  rsp_t want;
  rsp_t got;

  task automatic report(input string what);
    if (mismatches_o < 40) begin
      $display("checker: %0t ns: %s", $time, what);
    end
    mismatches_o++;
  endtask

  // Walks the probe sequence for one request and applies a set to the table copy.
  function automatic rsp_t probe_and_apply(input req_t r);
    int unsigned lg;
    int unsigned size;
    int unsigned cap;
    int unsigned idx;
    int unsigned step;
    logic        hit;
    logic        empty;
    rsp_t        res;
    lg = size_log2;
    if (lg < MIN_LOG2) lg = MIN_LOG2;
    if (lg > MAX_SLOTS_LOG2) lg = MAX_SLOTS_LOG2;
    size  = 1 << lg;
    cap   = (size * LOAD_NUM) >> LOAD_SHIFT;
    idx   = r.key_hash & (size - 1);
    hit   = 1'b0;
    empty = 1'b0;
    for (step = 1; step <= size; step++) begin
      if (!slot_full[idx]) begin
        empty = 1'b1;
        break;
      end
      if (slot_key[idx] == r.key_id) begin
        hit = 1'b1;
        break;
      end
      idx = (idx + step) & (size - 1);
    end
    res       = '0;
    res.found = hit;
    if (r.kind == KIND_FIND) begin
      if (hit) res.value_out = slot_val[idx];
    end else if (hit) begin
      slot_val[idx] = r.value_in;
    end else if (empty && fill_count <= cap) begin
      slot_full[idx] = 1'b1;
      slot_key[idx]  = r.key_id;
      slot_val[idx]  = r.value_in;
      fill_count++;
    end else begin
      res.refused = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) slot_full[s] = 1'b0;
      fill_count = 0;
      size_log2  = CFG_RESET;
      replies_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
      hits_o       = 0;
      refusals_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SIZE_REG_ADDR) begin
        size_log2 = pwdata_i[CFG_WIDTH-1:0];
      end
      if (rsp_valid_i && rsp_ready_i) begin
        results_o++;
        if (replies_due.size() == 0) begin
          report("reply transfer with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          if (rsp_i.found !== want.found) begin
            report($sformatf("found %b, expected %b", rsp_i.found, want.found));
          end
          if (rsp_i.value_out !== want.value_out) begin
            report($sformatf("value_out %h, expected %h", rsp_i.value_out, want.value_out));
          end
          if (rsp_i.refused !== want.refused) begin
            report($sformatf("refused %b, expected %b", rsp_i.refused, want.refused));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        got = probe_and_apply(req_i);
        replies_due.push_back(got);
        if (got.found) hits_o++;
        if (got.refused) refusals_o++;
      end
      pending_o = replies_due.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the hash map testbench: clock, reset, request and reply traffic, register writes.
// Depends on hmtp_pkg, the hash_map_triangular_probe RTL and bench/hmtp_checker.sv.
`timescale 1ns / 1ps

module tb;

  import hmtp_pkg::*;

  // Register i sits at byte address 4*i. The address one past the size register maps
  // to nothing, and a write there must leave the table size alone.
  localparam int unsigned SIZE_REG_INDEX = REG_TABLE_SIZE_LOG2;
  localparam logic [31:0] SIZE_REG_BYTE  = 4 * SIZE_REG_INDEX;
  localparam logic [31:0] UNMAPPED_BYTE  = 4 * (SIZE_REG_INDEX + 1);
  localparam logic [APB_ADDR_W-1:0] SIZE_REG_ADDR = SIZE_REG_BYTE[APB_ADDR_W-1:0];
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = UNMAPPED_BYTE[APB_ADDR_W-1:0];
  localparam int unsigned PHASES = 13;
  localparam int unsigned ITEMS_PER_PHASE = 54;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  req_t                  req = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned hits;
  int unsigned refusals;

  // Sender burst state and the receiver's stall pattern.
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  // Keys of the current phase, and keys that have been sent with a set so far.
  logic [31:0] pool_key [$];
  logic [31:0] pool_hash [$];
  logic [31:0] seen_key [$];
  logic [31:0] seen_hash [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hash_map_triangular_probe dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hmtp_checker #(
    .SIZE_REG_ADDR (SIZE_REG_ADDR)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (in_valid),
    .req_ready_i  (in_ready),
    .req_i        (req),
    .rsp_valid_i  (out_valid),
    .rsp_ready_i  (out_ready),
    .rsp_i        (rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits),
    .refusals_o   (refusals)
  );

  // The receiver switches between stall patterns at random intervals: always ready,
  // a coin toss, mostly stalled, and a fixed three-in-seven rhythm. The always-ready
  // stretches give runs with no backpressure at all.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rx_tick % 7) < 3);
    endcase
  end

  // One request transfer. The sender works in bursts: when a burst runs out, valid
  // drops for a random gap and a new burst length is drawn. Within a burst valid stays
  // high and only the payload changes after each transfer. Called and returns at a
  // falling edge.
  task automatic send(input kind_e k, input logic [31:0] key, input logic [31:0] hash,
                      input logic [31:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req      <= '{kind: k, key_id: key, key_hash: hash, value_in: val};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds the sender off until every reply owed has come back, so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Register write: a setup phase, then an access phase that ends on pready.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned phase_sizes [PHASES];
    int unsigned pick;
    int unsigned n;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] val;
    kind_e       k;

    // Small tables first while the entry count is still low, then the full size, then
    // back to tiny tables where everything is full, and the out-of-range settings.
    phase_sizes = '{4, 5, 6, 7, 8, 9, 10, 11, 2, 1, 0, 3, 14};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset size of 1024 slots. A find on the empty table misses,
    // then an all-ones key lands in the last slot and is read back and overwritten with
    // a zero value, which must still count as stored.
    send(KIND_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 32'hDEAD_BEEF);
    send(KIND_SET,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send(KIND_SET,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    // Key zero is an ordinary key; only the slot's valid flag marks it empty.
    send(KIND_SET,  32'h0000_0000, 32'h0000_0005, 32'h1234_5678);
    send(KIND_FIND, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
    // Collisions: key 2 starts at the occupied last slot and wraps to slot 0; key 3
    // starts at slot 0 and moves on to slot 1. Key 4 walks the chain into an empty slot.
    send(KIND_SET,  32'h0000_0002, 32'h0000_03FF, 32'hA5A5_A5A5);
    send(KIND_SET,  32'h0000_0003, 32'h0000_0400, 32'h5A5A_5A5A);
    send(KIND_FIND, 32'h0000_0003, 32'h0000_0400, 32'h0000_0000);
    send(KIND_FIND, 32'h0000_0004, 32'h0000_03FF, 32'h0000_0000);
    drain();

    // A size of zero acts as two slots. Both are taken, so key zero in slot 5 is out of
    // reach, a new key walks the whole table and is refused, and an update still works.
    cfg_write(SIZE_REG_ADDR, 32'h0000_0000);
    send(KIND_FIND, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
    send(KIND_SET,  32'h0000_0007, 32'h0000_0000, 32'h0000_0007);
    send(KIND_SET,  32'h0000_0003, 32'h0000_0001, 32'h0000_0001);
    send(KIND_FIND, 32'h0000_0003, 32'h0000_0000, 32'h0000_0000);
    drain();

    // Eight slots give a load limit of six, and a new key is still taken at the limit, so
    // seven entries fit. Four are counted already, so three more go in and the next new
    // key is refused at an empty slot. Updating an existing key is never refused.
    cfg_write(SIZE_REG_ADDR, 32'h0000_0003);
    send(KIND_SET,  32'h0000_0010, 32'h0000_0002, 32'h0000_0010);
    send(KIND_SET,  32'h0000_0011, 32'h0000_0002, 32'h0000_0011);
    send(KIND_SET,  32'h0000_0012, 32'h0000_0002, 32'h0000_0012);
    send(KIND_SET,  32'h0000_0013, 32'h0000_0006, 32'h0000_0013);
    send(KIND_SET,  32'h0000_0010, 32'h0000_0002, 32'h0000_0000);
    send(KIND_FIND, 32'h0000_0013, 32'h0000_0006, 32'h0000_0000);
    drain();

    // A write to the unmapped address must not change the size: still eight slots,
    // still over the limit.
    cfg_write(UNMAPPED_ADDR, 32'h0000_0002);
    send(KIND_SET,  32'h0000_0014, 32'h0000_0006, 32'h0000_0014);
    drain();

    // Fifteen clamps to the largest table. The last slot is reachable again, and a key
    // stored under the small table sits off the new probe path.
    cfg_write(SIZE_REG_ADDR, 32'hFFFF_FFFF);
    send(KIND_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send(KIND_FIND, 32'h0000_0012, 32'h0000_0002, 32'h0000_0000);
    drain();

    // Random part. Each phase sets a size and draws a small pool of keys; half of the
    // pool hashes into the first eight slots so that chains form at every size. Most
    // requests reuse pool keys or keys set earlier, which gives hits and updates; the
    // rest are the same key under a wrong hash, or a fresh key altogether.
    for (int p = 0; p < PHASES; p++) begin
      cfg_write(SIZE_REG_ADDR, ($urandom() & 32'hFFFF_FFF0) | phase_sizes[p]);
      pool_key.delete();
      pool_hash.delete();
      repeat ($urandom_range(6, 24)) begin
        pool_key.push_back($urandom());
        if ($urandom_range(0, 1) == 1) begin
          pool_hash.push_back(($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 7));
        end else begin
          pool_hash.push_back($urandom());
        end
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          n    = $urandom_range(0, pool_key.size() - 1);
          key  = pool_key[n];
          hash = pool_hash[n];
        end else if (pick < 85 && seen_key.size() != 0) begin
          n    = $urandom_range(0, seen_key.size() - 1);
          key  = seen_key[n];
          hash = seen_hash[n];
        end else if (pick < 92) begin
          n    = $urandom_range(0, pool_key.size() - 1);
          key  = pool_key[n];
          hash = $urandom();
        end else begin
          key  = $urandom();
          hash = $urandom();
        end
        k = ($urandom_range(0, 99) < 45) ? KIND_SET : KIND_FIND;
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = '1;
          default: val = $urandom();
        endcase
        if (k == KIND_SET && seen_key.size() < 256) begin
          seen_key.push_back(key);
          seen_hash.push_back(hash);
        end
        send(k, key, hash, val);
        // Now and then the sender waits for the block to go fully idle.
        if ($urandom_range(0, 59) == 0) drain();
      end
      drain();
    end

    // Everything has been sent; give the block a margin past its last reply.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("tb: %0d replies checked, %0d hits, %0d refused sets, %0d mismatches",
             results, hits, refusals, mismatches);
    $display("tb: sizes 2 to 1024 slots incl. clamped settings, load limit, full probe, shrink");
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
